/* rtl/voc_pcm8_resample_pan_macros.svh */
// Assertion macros for the resampler RTL.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef VOC_PCM8_RESAMPLE_PAN_MACROS_SVH
`define VOC_PCM8_RESAMPLE_PAN_MACROS_SVH

// same-cycle implication
`define VOCRS_AST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VOCRS_AST_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/vocrs_pkg.sv */
// Types and constants of the VOC PCM resampler.
// No dependencies.
`default_nettype none
package vocrs_pkg;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } vocrs_in_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] smp_l;
      logic signed [15:0] smp_r;
      logic [3:0]         status_code;
      logic               final_item;
   } vocrs_out_type;

   typedef struct packed {
      logic [15:0] output_rate;
      logic [7:0]  volume;
      logic [7:0]  pan;
      logic [23:0] file_length;
   } vocrs_cfg_type;

   // one command per file byte that causes work in the back end
   typedef struct packed {
      logic        setup;
      logic [7:0]  rate_code;
      logic        run1;
      logic        run2;
      logic [7:0]  prev_pcm;
      logic [7:0]  cur_pcm;
      logic [23:0] index;
      logic        status;
      logic [3:0]  status_code;
   } vocrs_cmd_type;

   localparam logic [1:0] CsrOutputRate = 2'd0;
   localparam logic [1:0] CsrVolume     = 2'd1;
   localparam logic [1:0] CsrPan        = 2'd2;
   localparam logic [1:0] CsrFileLength = 2'd3;

   localparam logic [3:0] StatOk        = 4'd0;
   localparam logic [3:0] StatShort     = 4'd1;
   localparam logic [3:0] StatSignature = 4'd2;
   localparam logic [3:0] StatOffset    = 4'd3;
   localparam logic [3:0] StatBlockType = 4'd4;
   localparam logic [3:0] StatLength    = 4'd5;
   localparam logic [3:0] StatCodec     = 4'd6;
   localparam logic [3:0] StatNoPcm     = 4'd7;
   localparam logic [3:0] StatTruncated = 4'd8;

   localparam logic       KindFrame  = 1'b0;
   localparam logic       KindStatus = 1'b1;

endpackage
`default_nettype wire

/* rtl/voc_pcm8_resample_pan.sv */
// Top level of the VOC 8-bit PCM resampler with volume and pan.
// Depends on vocrs_pkg, vocrs_front, vocrs_cmdq, vocrs_back.
//
// chan  dir  handshake              payload
// req   in   req_valid / req_stall  req_data  (vocrs_in_type)
// rsp   out  rsp_valid / rsp_stall  rsp_data  (vocrs_out_type)
// csr   in   csr_write              csr_index, csr_wdata
//
// The parser takes one file byte per cycle while the two-deep command queue has room.
// Each frame waits on the shared divider twice (interpolation fraction, then phase step)
// and also on any result stall; a codec byte adds the gain steps and a rate division.
// Reset is synchronous; there is no clearing pass.
// rsp_stall holds the result register; the back end then waits, the queue fills
// and req_stall rises.
`default_nettype none
module voc_pcm8_resample_pan
   import vocrs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire vocrs_in_type  req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output vocrs_out_type      rsp_data,
   input  wire logic          csr_write,
   input  wire logic [1:0]    csr_index,
   input  wire logic [23:0]   csr_wdata
);
   vocrs_cfg_type cfg_ff, cfg_in;
   logic          q_full, q_avail, q_pop, push, accept;
   vocrs_cmd_type push_data, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CsrOutputRate: cfg_in.output_rate = csr_wdata[15:0];
            CsrVolume:     cfg_in.volume      = csr_wdata[7:0];
            CsrPan:        cfg_in.pan         = csr_wdata[7:0];
            CsrFileLength: cfg_in.file_length = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_rate <= 16'd32000;
         cfg_ff.volume      <= 8'd127;
         cfg_ff.pan         <= 8'd64;
         cfg_ff.file_length <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   vocrs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_data     (req_data),
      .file_length (cfg_ff.file_length),
      .push        (push),
      .push_data   (push_data)
   );

   vocrs_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_avail),
      .head      (q_head)
   );

   vocrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_avail (q_avail),
      .cmd_head  (q_head),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/vocrs_div.sv */
// Restoring divider, one quotient bit per cycle.
// Uses vocrs_pkg only for house consistency of types; no submodules.
`default_nettype none
module vocrs_div
   import vocrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [15:0]      remainder
);
   localparam int Width = 32;
   localparam int CntW  = $clog2(Width);
   localparam logic [CntW-1:0] LastStep = CntW'(Width - 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [15:0]     acc_ff, acc_in;
   logic [31:0]     quo_ff, quo_in;
   logic [15:0]     dsr_ff, dsr_in;
   logic [16:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {acc_ff, quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            acc_in = 16'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            acc_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = acc_ff;

endmodule
`default_nettype wire

/* rtl/vocrs_cmdq.sv */
// Two-entry command queue between the parser and the frame engine.
// Depends on vocrs_pkg for the command type.
`default_nettype none
module vocrs_cmdq
   import vocrs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire vocrs_cmd_type push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output vocrs_cmd_type      head
);
   vocrs_cmd_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* rtl/vocrs_front.sv */
// File parser: checks header and block, tracks byte position, issues commands.
// Depends on vocrs_pkg.
`default_nettype none
module vocrs_front
   import vocrs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire vocrs_in_type  in_data,
   input  wire logic [23:0]   file_length,
   output logic               push,
   output vocrs_cmd_type      push_data
);
   typedef enum logic [4:0] {
      ST_HEADER = 5'b00001,
      ST_BLOCK  = 5'b00010,
      ST_PCM    = 5'b00100,
      ST_DONE   = 5'b01000,
      ST_ERROR  = 5'b10000
   } stage_type;

   localparam logic [24:0] PosMax = '1;

   function automatic logic [7:0] sig_byte(input logic [4:0] i);
      logic [7:0] b;
      case (i)
         5'd0:    b = 8'h43;
         5'd1:    b = 8'h72;
         5'd2:    b = 8'h65;
         5'd3:    b = 8'h61;
         5'd4:    b = 8'h74;
         5'd5:    b = 8'h69;
         5'd6:    b = 8'h76;
         5'd7:    b = 8'h65;
         5'd8:    b = 8'h20;
         5'd9:    b = 8'h56;
         5'd10:   b = 8'h6F;
         5'd11:   b = 8'h69;
         5'd12:   b = 8'h63;
         5'd13:   b = 8'h65;
         5'd14:   b = 8'h20;
         5'd15:   b = 8'h46;
         5'd16:   b = 8'h69;
         5'd17:   b = 8'h6C;
         5'd18:   b = 8'h65;
         5'd19:   b = 8'h1A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   stage_type   stage_ff, stage_in;
   logic [24:0] pos_ff, pos_in;
   logic [15:0] ds_ff, ds_in;
   logic [23:0] pcm_ff, pcm_in;
   logic [7:0]  rate_ff, rate_in;
   logic [7:0]  prev_ff, prev_in;
   logic [3:0]  err_ff, err_in;

   logic [7:0]  v;
   logic [24:0] off;
   logic [24:0] kpos;
   logic [15:0] ds_new;
   logic [23:0] pcm_new;
   vocrs_cmd_type cmd;

   always_comb begin
      stage_in = stage_ff;
      pos_in   = pos_ff;
      ds_in    = ds_ff;
      pcm_in   = pcm_ff;
      rate_in  = rate_ff;
      prev_in  = prev_ff;
      err_in   = err_ff;
      v        = in_data.file_byte;
      off      = pos_ff - 25'(ds_ff);
      kpos     = pos_ff - (25'(ds_ff) + 25'd6);
      ds_new   = {v, ds_ff[7:0]};
      pcm_new  = pcm_ff;
      cmd      = '0;
      push     = 1'b0;

      if (accept) begin
         if (pos_ff != PosMax) begin
            pos_in = pos_ff + 1'b1;
         end
         case (stage_ff)
            ST_HEADER: begin
               if (pos_ff == '0 && file_length < 24'd27) begin
                  stage_in = ST_ERROR;
                  err_in   = StatShort;
               end else if (pos_ff < 25'd20) begin
                  if (v != sig_byte(pos_ff[4:0])) begin
                     stage_in = ST_ERROR;
                     err_in   = StatSignature;
                  end
               end else if (pos_ff == 25'd20) begin
                  ds_in = {8'h00, v};
               end else if (pos_ff == 25'd21) begin
                  ds_in = ds_new;
                  if (24'(ds_new) >= file_length || ds_new < 16'd26) begin
                     stage_in = ST_ERROR;
                     err_in   = StatOffset;
                  end
               end else if (pos_ff == 25'd25) begin
                  stage_in = ST_BLOCK;
               end
            end
            ST_BLOCK: begin
               if (pos_ff >= 25'(ds_ff)) begin
                  if (off == 25'd0) begin
                     if (v != 8'd1 || 25'(ds_ff) + 25'd4 > 25'(file_length)) begin
                        stage_in = ST_ERROR;
                        err_in   = StatBlockType;
                     end
                  end else if (off == 25'd1) begin
                     pcm_in = pcm_ff | {16'h0000, v};
                  end else if (off == 25'd2) begin
                     pcm_in = pcm_ff | {8'h00, v, 8'h00};
                  end else if (off == 25'd3) begin
                     pcm_new = pcm_ff | {v, 16'h0000};
                     pcm_in  = pcm_new;
                     if (pcm_new < 24'd2 ||
                         25'(ds_ff) + 25'd4 + 25'(pcm_new) > 25'(file_length)) begin
                        stage_in = ST_ERROR;
                        err_in   = StatLength;
                     end
                  end else if (off == 25'd4) begin
                     rate_in = v;
                  end else begin
                     if (v != 8'd0) begin
                        stage_in = ST_ERROR;
                        err_in   = StatCodec;
                     end else if (pcm_ff == 24'd2) begin
                        stage_in = ST_ERROR;
                        err_in   = StatNoPcm;
                     end else begin
                        pcm_in        = pcm_ff - 24'd2;
                        prev_in       = 8'd128;
                        stage_in      = ST_PCM;
                        cmd.setup     = 1'b1;
                        cmd.rate_code = rate_ff;
                        push          = 1'b1;
                     end
                  end
               end
            end
            ST_PCM: begin
               cmd.prev_pcm = prev_ff;
               cmd.cur_pcm  = v;
               cmd.index    = kpos[23:0];
               cmd.run1     = (kpos != 25'd0);
               cmd.run2     = (kpos + 25'd1 >= 25'(pcm_ff));
               push         = cmd.run1 || cmd.run2;
               if (cmd.run2) begin
                  stage_in = ST_DONE;
               end
               prev_in = v;
            end
            ST_DONE, ST_ERROR: begin
            end
            default: begin
               stage_in = ST_HEADER;
            end
         endcase

         if (in_data.end_of_file) begin
            cmd.status = 1'b1;
            if (stage_in == ST_DONE) begin
               cmd.status_code = StatOk;
            end else if (stage_in == ST_ERROR) begin
               cmd.status_code = err_in;
            end else begin
               cmd.status_code = StatTruncated;
            end
            push     = 1'b1;
            stage_in = ST_HEADER;
            pos_in   = '0;
            ds_in    = '0;
            pcm_in   = '0;
            rate_in  = '0;
            prev_in  = 8'd128;
            err_in   = StatOk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_HEADER;
         pos_ff   <= '0;
         ds_ff    <= '0;
         pcm_ff   <= '0;
         rate_ff  <= '0;
         prev_ff  <= 8'd128;
         err_ff   <= StatOk;
      end else begin
         stage_ff <= stage_in;
         pos_ff   <= pos_in;
         ds_ff    <= ds_in;
         pcm_ff   <= pcm_in;
         rate_ff  <= rate_in;
         prev_ff  <= prev_in;
         err_ff   <= err_in;
      end
   end

   assign push_data = cmd;

endmodule
`default_nettype wire

/* rtl/vocrs_back.sv */
// Frame engine: gains, source rate, interpolation, scaling, result register.
// Depends on vocrs_pkg, vocrs_div and the assertion macro header.
`default_nettype none
`include "voc_pcm8_resample_pan_macros.svh"
module vocrs_back
   import vocrs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire vocrs_cfg_type cfg,
   input  wire logic          cmd_avail,
   input  wire vocrs_cmd_type cmd_head,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output vocrs_out_type      rsp_data
);
   typedef enum logic [15:0] {
      B_IDLE   = 16'b0000000000000001,
      B_GAIN_A = 16'b0000000000000010,
      B_GAIN_B = 16'b0000000000000100,
      B_GAIN_C = 16'b0000000000001000,
      B_GAIN_D = 16'b0000000000010000,
      B_RATE   = 16'b0000000000100000,
      B_RWAIT  = 16'b0000000001000000,
      B_CHECK  = 16'b0000000010000000,
      B_MUL1   = 16'b0000000100000000,
      B_DIV1   = 16'b0000001000000000,
      B_WAIT1  = 16'b0000010000000000,
      B_SCALE  = 16'b0000100000000000,
      B_DIVG   = 16'b0001000000000000,
      B_EMIT   = 16'b0010000000000000,
      B_PHASE  = 16'b0100000000000000,
      B_STATUS = 16'b1000000000000000
   } bstate_type;

   localparam logic [4:0] FrameCap = 5'd31;

   function automatic logic [6:0] div63(input logic [13:0] x);
      logic [31:0] p;
      logic [6:0]  q;
      logic [13:0] r;
      p = 32'(x) * 32'd4161;
      q = p[24:18];
      r = x - 14'(q) * 14'd63;
      if (r >= 14'd63) begin
         q = q + 1'b1;
      end
      return q;
   endfunction

   function automatic logic [15:0] div127(input logic [21:0] x);
      logic [43:0] p;
      logic [15:0] q;
      logic [21:0] r;
      p = 44'(x) * 44'd2113665;
      q = p[43:28];
      r = x - 22'(q) * 22'd127;
      if (r >= 22'd127) begin
         q = q + 1'b1;
      end
      return q;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
      logic signed [15:0] y;
      if (x > 17'sd32767) begin
         y = 16'sh7FFF;
      end else if (x < -17'sd32768) begin
         y = 16'sh8000;
      end else begin
         y = x[15:0];
      end
      return y;
   endfunction

   bstate_type         state_ff, state_in;
   vocrs_cmd_type      cmd_ff, cmd_in;
   logic               run1_ff, run1_in;
   logic               run2_ff, run2_in;
   logic               stat_ff, stat_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [24:0]        src_ff, src_in;
   logic [15:0]        ph_ff, ph_in;
   logic [19:0]        srv_ff, srv_in;
   logic [6:0]         gain_l_ff, gain_l_in;
   logic [6:0]         gain_r_ff, gain_r_in;
   logic               side_ff, side_in;
   logic [6:0]         lp_ff, lp_in;
   logic [6:0]         rp_ff, rp_in;
   logic [21:0]        mul_l_ff, mul_l_in;
   logic [21:0]        mul_r_ff, mul_r_in;
   logic               neg_ff, neg_in;
   logic [31:0]        prod_ff, prod_in;
   logic               dneg_ff, dneg_in;
   logic signed [16:0] base_ff, base_in;
   logic signed [16:0] s_ff, s_in;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;
   vocrs_out_type      out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic [15:0] f_eff;
   logic [6:0]  vol_c, pan_c;
   logic [7:0]  pa, pb;
   logic [23:0] idx;
   logic        due;
   logic [8:0]  diff9, a9;
   logic [7:0]  dmag;
   logic [16:0] smag;
   logic [6:0]  g63;
   logic [8:0]  dcode;
   logic [16:0] vl, vr;
   logic        slot_free, out_load;
   logic        div_start, div_busy, div_done;
   logic [31:0] div_dividend, div_quo;
   logic [15:0] div_divisor, div_rem;

   always_comb begin
      if (cfg.output_rate < 16'd4000) begin
         f_eff = 16'd4000;
      end else if (cfg.output_rate > 16'd48000) begin
         f_eff = 16'd48000;
      end else begin
         f_eff = cfg.output_rate;
      end
      vol_c = cfg.volume[7] ? 7'd127 : cfg.volume[6:0];
      if (cfg.pan == 8'd0) begin
         pan_c = 7'd1;
      end else if (cfg.pan[7]) begin
         pan_c = 7'd127;
      end else begin
         pan_c = cfg.pan[6:0];
      end
   end

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign dcode     = 9'd256 - {1'b0, cmd_ff.rate_code};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      run1_in      = run1_ff;
      run2_in      = run2_ff;
      stat_in      = stat_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      ph_in        = ph_ff;
      srv_in       = srv_ff;
      gain_l_in    = gain_l_ff;
      gain_r_in    = gain_r_ff;
      side_in      = side_ff;
      lp_in        = lp_ff;
      rp_in        = rp_ff;
      mul_l_in     = mul_l_ff;
      mul_r_in     = mul_r_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      dneg_in      = dneg_ff;
      base_in      = base_ff;
      s_in         = s_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      out_load     = 1'b0;
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = f_eff;

      pa    = run1_ff ? cmd_ff.prev_pcm : cmd_ff.cur_pcm;
      pb    = cmd_ff.cur_pcm;
      idx   = run1_ff ? cmd_ff.index - 24'd1 : cmd_ff.index;
      due   = (run1_ff || run2_ff) && (25'(idx) >= src_ff) && (cnt_ff != FrameCap);
      a9    = {1'b0, pa} - 9'd128;
      diff9 = {1'b0, pb} - {1'b0, pa};
      dmag  = diff9[8] ? 8'(-diff9) : diff9[7:0];
      smag  = s_ff[16] ? 17'(-s_ff) : 17'(s_ff);
      g63   = div63(mul_l_ff[13:0]);
      vl    = neg_ff ? 17'(-{1'b0, div127(mul_l_ff)}) : {1'b0, div127(mul_l_ff)};
      vr    = neg_ff ? 17'(-{1'b0, div127(mul_r_ff)}) : {1'b0, div127(mul_r_ff)};

      case (state_ff)
         B_IDLE: begin
            if (cmd_avail) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               run1_in  = cmd_head.run1;
               run2_in  = cmd_head.run2;
               stat_in  = cmd_head.status;
               cnt_in   = '0;
               state_in = cmd_head.setup ? B_GAIN_A : B_CHECK;
            end
         end
         B_GAIN_A: begin
            side_in = (pan_c <= 7'd64);
            if (pan_c <= 7'd64) begin
               mul_l_in = 22'(14'(pan_c) * 14'd127);
            end else begin
               mul_l_in = 22'(14'(7'd127 - pan_c) * 14'd127);
            end
            state_in = B_GAIN_B;
         end
         B_GAIN_B: begin
            if (side_ff) begin
               lp_in = 7'd127;
               rp_in = mul_l_ff[12:6];
            end else begin
               lp_in = g63;
               rp_in = 7'd127;
            end
            state_in = B_GAIN_C;
         end
         B_GAIN_C: begin
            mul_l_in = 22'(14'(vol_c) * 14'(lp_ff));
            mul_r_in = 22'(14'(vol_c) * 14'(rp_ff));
            neg_in   = 1'b0;
            state_in = B_GAIN_D;
         end
         B_GAIN_D: begin
            gain_l_in = vl[6:0];
            gain_r_in = vr[6:0];
            state_in  = B_RATE;
         end
         B_RATE: begin
            div_start    = 1'b1;
            div_dividend = 32'(20'd1000000 + 20'(dcode >> 1));
            div_divisor  = 16'(dcode);
            state_in     = B_RWAIT;
         end
         B_RWAIT: begin
            if (div_done) begin
               srv_in   = div_quo[19:0];
               src_in   = '0;
               ph_in    = '0;
               state_in = B_CHECK;
            end
         end
         B_CHECK: begin
            if (due) begin
               state_in = B_MUL1;
            end else if (run1_ff) begin
               run1_in = 1'b0;
            end else if (run2_ff) begin
               run2_in = 1'b0;
            end else if (stat_ff) begin
               state_in = B_STATUS;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_MUL1: begin
            prod_in  = {24'(dmag * ph_ff), 8'h00};
            dneg_in  = diff9[8];
            base_in  = {a9, 8'h00};
            state_in = B_DIV1;
         end
         B_DIV1: begin
            div_start = 1'b1;
            state_in  = B_WAIT1;
         end
         B_WAIT1: begin
            if (div_done) begin
               s_in     = dneg_ff ? base_ff - signed'({1'b0, div_quo[15:0]})
                                  : base_ff + signed'({1'b0, div_quo[15:0]});
               state_in = B_SCALE;
            end
         end
         B_SCALE: begin
            mul_l_in = 22'(24'(smag) * 24'(gain_l_ff));
            mul_r_in = 22'(24'(smag) * 24'(gain_r_ff));
            neg_in   = s_ff[16];
            state_in = B_DIVG;
         end
         B_DIVG: begin
            left_in  = sat16(signed'(vl));
            right_in = sat16(signed'(vr));
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (slot_free) begin
               out_load            = 1'b1;
               out_in.kind         = KindFrame;
               out_in.smp_l        = left_ff;
               out_in.smp_r        = right_ff;
               out_in.status_code  = StatOk;
               out_in.final_item   = 1'b0;
               cnt_in              = cnt_ff + 1'b1;
               // phase step: quotient advances the source index
               div_start           = 1'b1;
               div_dividend        = 32'(21'(ph_ff) + 21'(srv_ff));
               state_in            = B_PHASE;
            end
         end
         B_PHASE: begin
            if (div_done) begin
               src_in   = src_ff + 25'(div_quo);
               ph_in    = div_rem;
               state_in = B_CHECK;
            end
         end
         B_STATUS: begin
            if (slot_free) begin
               out_load            = 1'b1;
               out_in.kind         = KindStatus;
               out_in.smp_l        = '0;
               out_in.smp_r        = '0;
               out_in.status_code  = cmd_ff.status_code;
               out_in.final_item   = 1'b1;
               stat_in             = 1'b0;
               state_in            = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   vocrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         run1_ff      <= 1'b0;
         run2_ff      <= 1'b0;
         stat_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run1_ff      <= run1_in;
         run2_ff      <= run2_in;
         stat_ff      <= stat_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      src_ff    <= src_in;
      ph_ff     <= ph_in;
      srv_ff    <= srv_in;
      gain_l_ff <= gain_l_in;
      gain_r_ff <= gain_r_in;
      side_ff   <= side_in;
      lp_ff     <= lp_in;
      rp_ff     <= rp_in;
      mul_l_ff  <= mul_l_in;
      mul_r_ff  <= mul_r_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      dneg_ff   <= dneg_in;
      base_ff   <= base_in;
      s_ff      <= s_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `VOCRS_AST(a_out_hold, out_valid_ff && rsp_stall, !out_load, "result overwritten while stalled")
   `VOCRS_AST(a_div_idle, div_start, !div_busy, "divider restarted while busy")
   `VOCRS_AST(a_frame_cap, state_ff == B_MUL1, cnt_ff != FrameCap, "frame cap exceeded")

endmodule
`default_nettype wire
